@@ hdl/xpl_pkg.sv @@
package xpl_pkg;

	// one input beat
	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_string;
	} in_item_t;

	// one result beat, step record or verdict record
	typedef struct packed {
		logic        final_record;
		logic        accepted;
		logic [15:0] doc_fragment;
		logic [30:0] char_offset;
		logic        has_char_offset;
		logic        has_text_terminal;
		logic        explicit_text_index;
		logic [15:0] text_node_index;
		logic [5:0]  step_count;
		logic [15:0] sibling_index;
		logic [8:0]  tag_start;
		logic [4:0]  tag_length;
	} rec_t;

	typedef enum logic [4:0] {
		PH_PREFIX,
		PH_FRAG_NUM,
		PH_AFTER_FRAG,
		PH_FRAG_OFF,
		PH_BODY,
		PH_BODY_DONE,
		PH_BODY_SLASH,
		PH_STEP_SLASH,
		PH_TAG,
		PH_SIB_NUM,
		PH_AFTER_STEP,
		PH_TEXT_CLOSE,
		PH_TEXT_AFTER,
		PH_TEXT_NUM,
		PH_TEXT_DONE,
		PH_OFF_NUM
	} phase_t;

	localparam logic [4:0]  LEAD_LEN    = 5'd18;  // "/body/DocFragment["
	localparam logic [4:0]  BODY_LEN    = 5'd5;   // "/body"
	localparam logic [2:0]  WORD_LEN    = 3'd4;   // "text"
	localparam logic [2:0]  WORD_BROKEN = 3'd7;
	localparam logic [30:0] MAX_SHORT   = 31'd65535;
	localparam logic [30:0] MAX_OFFSET  = 31'h7FFF_FFFF;

	function automatic logic [7:0] lead_char(input logic [4:0] idx);
		logic [7:0] ch;
		unique case (idx)
			5'd0:    ch = "/";
			5'd1:    ch = "b";
			5'd2:    ch = "o";
			5'd3:    ch = "d";
			5'd4:    ch = "y";
			5'd5:    ch = "/";
			5'd6:    ch = "D";
			5'd7:    ch = "o";
			5'd8:    ch = "c";
			5'd9:    ch = "F";
			5'd10:   ch = "r";
			5'd11:   ch = "a";
			5'd12:   ch = "g";
			5'd13:   ch = "m";
			5'd14:   ch = "e";
			5'd15:   ch = "n";
			5'd16:   ch = "t";
			5'd17:   ch = "[";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] body_char(input logic [4:0] idx);
		logic [7:0] ch;
		unique case (idx)
			5'd0:    ch = "/";
			5'd1:    ch = "b";
			5'd2:    ch = "o";
			5'd3:    ch = "d";
			5'd4:    ch = "y";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] word_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0:    ch = "t";
			3'd1:    ch = "e";
			3'd2:    ch = "x";
			3'd3:    ch = "t";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

@@ hdl/xpl_stream_if.sv @@
interface xpl_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/xpath_locator_parser.sv @@
// Channel   Direction  Payload      Beat
// bytes     sink       in_item_t    one path byte, end_of_string on the last one
// records   source     rec_t        one step record or one verdict record
//
// A byte is taken into the input register and parsed from there, where all state
// updates and up to two records are produced in one pass; one byte per cycle while
// the queue has room. Records leave through a three-slot result queue, one beat per
// cycle while records.ready is high; a byte ending a step and the path queues two.
// bytes.ready drops only while the queue lacks room for the held byte's records.
// Reset (arst_n low) returns the parser to prefix matching and empties the queue.
module xpath_locator_parser #(
	parameter int MAX_PATH_BYTES = 512,
	parameter int MAX_STEPS      = 32,
	parameter int MAX_NAME_BYTES = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	xpl_stream_if.sink   bytes,
	xpl_stream_if.source records
);
	import xpl_pkg::*;

	localparam int POS_W  = $clog2(MAX_PATH_BYTES + 2);
	localparam int NAME_W = $clog2(MAX_NAME_BYTES + 1);
	localparam int QDEPTH = 3;

	// input register
	logic       valid_s1;
	in_item_t   item_s1;

	// parser state
	phase_t            phase_q, phase_n;
	logic [POS_W-1:0]  pos_q, pos_n;
	logic [4:0]        pmi_q, pmi_n;
	logic [30:0]       acc_q, acc_n;
	logic              saw_q, saw_n;
	logic [15:0]       frag_q, frag_n;
	logic              text_seen_q, text_seen_n;
	logic              expl_q, expl_n;
	logic [15:0]       tidx_q, tidx_n;
	logic [5:0]        steps_q, steps_n;
	logic [8:0]        tstart_q, tstart_n;
	logic [NAME_W-1:0] tlen_q, tlen_n;
	logic [2:0]        word_q, word_n;
	logic [15:0]       sib_q, sib_n;
	logic              rej_q, rej_n;

	// per-byte decode
	logic [7:0]        ch;
	logic              last;
	logic              is_digit, is_name_start, is_name_char;
	logic [34:0]       prod;
	logic [30:0]       lim;
	logic              add_ok;
	logic              cmp, cmp_fail, step_emit, finish_ok, ok;
	logic [POS_W+8:0]  pos_ext;
	logic [NAME_W+4:0] tlen_ext;
	rec_t              step_rec, verdict_rec, first_rec, second_rec;

	// result queue
	rec_t       slot_q [QDEPTH];
	rec_t       slot_n [QDEPTH];
	logic [1:0] cnt_q, cnt_n;
	logic [1:0] need, base;
	logic [2:0] free;
	logic       pop, fire;

	assign ch   = item_s1.char_byte;
	assign last = item_s1.end_of_string;

	assign is_digit      = (ch >= "0") && (ch <= "9");
	assign is_name_start = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z")) ||
	                       (ch == "_");
	assign is_name_char  = is_name_start || is_digit || (ch == "-") || (ch == ":");

	// times-ten accumulate, checked against the field's maximum
	assign lim    = ((phase_q == PH_FRAG_OFF) || (phase_q == PH_OFF_NUM)) ? MAX_OFFSET
	                                                                      : MAX_SHORT;
	assign prod   = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {27'd0, ch - 8'd48};
	assign add_ok = prod <= {4'd0, lim};

	// next state
	always_comb begin
		phase_n     = phase_q;
		pos_n       = pos_q;
		pmi_n       = pmi_q;
		acc_n       = acc_q;
		saw_n       = saw_q;
		frag_n      = frag_q;
		text_seen_n = text_seen_q;
		expl_n      = expl_q;
		tidx_n      = tidx_q;
		steps_n     = steps_q;
		tstart_n    = tstart_q;
		tlen_n      = tlen_q;
		word_n      = word_q;
		sib_n       = sib_q;
		rej_n       = rej_q;
		cmp         = 1'b0;
		pos_ext     = (POS_W + 9)'(pos_q);

		if (pos_q <= POS_W'(MAX_PATH_BYTES)) begin
			pos_n = pos_q + 1'b1;
		end
		if (pos_n > POS_W'(MAX_PATH_BYTES)) begin
			rej_n = 1'b1;
		end

		if (!rej_n) begin
			unique case (phase_q) inside
				PH_PREFIX: begin
					if ((pmi_q < LEAD_LEN) && (ch == lead_char(pmi_q))) begin
						pmi_n = pmi_q + 1'b1;
						if (pmi_n == LEAD_LEN) begin
							acc_n   = '0;
							saw_n   = 1'b0;
							phase_n = PH_FRAG_NUM;
						end
					end else begin
						rej_n = 1'b1;
					end
				end
				PH_FRAG_NUM, PH_SIB_NUM, PH_TEXT_NUM: begin
					if (is_digit) begin
						if (add_ok) begin
							acc_n = prod[30:0];
							saw_n = 1'b1;
						end else begin
							rej_n = 1'b1;
						end
					end else if ((ch == "]") && saw_q && (phase_q == PH_SIB_NUM)) begin
						sib_n   = (acc_q != '0) ? acc_q[15:0] : 16'd1;
						cmp     = 1'b1;
						phase_n = PH_AFTER_STEP;
					end else if ((ch == "]") && saw_q && (acc_q != '0) &&
					             (phase_q == PH_FRAG_NUM)) begin
						frag_n  = acc_q[15:0];
						phase_n = PH_AFTER_FRAG;
					end else if ((ch == "]") && saw_q && (acc_q != '0) &&
					             (phase_q == PH_TEXT_NUM)) begin
						tidx_n  = acc_q[15:0];
						expl_n  = 1'b1;
						phase_n = PH_TEXT_DONE;
					end else begin
						rej_n = 1'b1;
					end
				end
				PH_AFTER_FRAG: begin
					if (ch == ".") begin
						acc_n   = '0;
						saw_n   = 1'b0;
						phase_n = PH_FRAG_OFF;
					end else if (ch == "/") begin
						pmi_n   = 5'd1;
						phase_n = PH_BODY;
					end else begin
						rej_n = 1'b1;
					end
				end
				PH_BODY: begin
					if ((pmi_q < BODY_LEN) && (ch == body_char(pmi_q))) begin
						pmi_n = pmi_q + 1'b1;
						if (pmi_n == BODY_LEN) begin
							phase_n = PH_BODY_DONE;
						end
					end else begin
						rej_n = 1'b1;
					end
				end
				PH_BODY_DONE: begin
					if (ch == "/") begin
						phase_n = PH_BODY_SLASH;
					end else begin
						rej_n = 1'b1;
					end
				end
				PH_BODY_SLASH, PH_STEP_SLASH: begin
					if (is_name_start) begin
						tstart_n = pos_ext[8:0];
						tlen_n   = NAME_W'(1);
						word_n   = (ch == "t") ? 3'd1 : WORD_BROKEN;
						sib_n    = 16'd1;
						phase_n  = PH_TAG;
					end else begin
						rej_n = 1'b1;
					end
				end
				PH_TAG: begin
					if (is_name_char) begin
						// saturate: any length at the limit is already too long
						if (tlen_q < NAME_W'(MAX_NAME_BYTES)) begin
							tlen_n = tlen_q + 1'b1;
						end
						if ((word_q < WORD_LEN) && (ch == word_char(word_q))) begin
							word_n = word_q + 1'b1;
						end else begin
							word_n = WORD_BROKEN;
						end
					end else if (ch == "(") begin
						if ((word_q == WORD_LEN) && (steps_q != '0)) begin
							phase_n = PH_TEXT_CLOSE;
						end else begin
							rej_n = 1'b1;
						end
					end else if (ch == "[") begin
						acc_n   = '0;
						saw_n   = 1'b0;
						phase_n = PH_SIB_NUM;
					end else if (ch == "/") begin
						cmp     = 1'b1;
						phase_n = PH_STEP_SLASH;
					end else if (ch == ".") begin
						cmp     = 1'b1;
						acc_n   = '0;
						saw_n   = 1'b0;
						phase_n = PH_OFF_NUM;
					end else begin
						rej_n = 1'b1;
					end
				end
				PH_AFTER_STEP, PH_TEXT_AFTER, PH_TEXT_DONE: begin
					if ((ch == "/") && (phase_q == PH_AFTER_STEP)) begin
						phase_n = PH_STEP_SLASH;
					end else if ((ch == "[") && (phase_q == PH_TEXT_AFTER)) begin
						acc_n   = '0;
						saw_n   = 1'b0;
						phase_n = PH_TEXT_NUM;
					end else if (ch == ".") begin
						acc_n   = '0;
						saw_n   = 1'b0;
						phase_n = PH_OFF_NUM;
					end else begin
						rej_n = 1'b1;
					end
				end
				PH_TEXT_CLOSE: begin
					if (ch == ")") begin
						text_seen_n = 1'b1;
						phase_n     = PH_TEXT_AFTER;
					end else begin
						rej_n = 1'b1;
					end
				end
				PH_FRAG_OFF, PH_OFF_NUM: begin
					if (is_digit && add_ok) begin
						acc_n = prod[30:0];
						saw_n = 1'b1;
					end else begin
						rej_n = 1'b1;
					end
				end
				default: begin
					rej_n = 1'b1;
				end
			endcase
		end

		// a path that ends inside a name closes that step
		if (last && !rej_n && (phase_n == PH_TAG)) begin
			cmp = 1'b1;
		end

		cmp_fail  = (tlen_n == '0) || (tlen_n >= NAME_W'(MAX_NAME_BYTES)) ||
		            (steps_q >= 6'(MAX_STEPS));
		step_emit = cmp && !cmp_fail;
		if (cmp && cmp_fail) begin
			rej_n = 1'b1;
		end
		if (step_emit) begin
			steps_n = steps_q + 1'b1;
		end

		case (phase_n)
			PH_AFTER_FRAG, PH_BODY_DONE, PH_BODY_SLASH, PH_AFTER_STEP, PH_TAG:
				finish_ok = 1'b1;
			PH_FRAG_OFF:
				finish_ok = saw_n && (acc_n == '0);
			PH_OFF_NUM:
				finish_ok = saw_n;
			default:
				finish_ok = 1'b0;
		endcase
		ok = !rej_n && finish_ok;
	end

	// record contents
	always_comb begin
		tlen_ext = (NAME_W + 5)'(tlen_n);

		step_rec                     = '0;
		step_rec.accepted            = 1'b1;
		step_rec.doc_fragment        = frag_n;
		step_rec.step_count          = steps_q;
		step_rec.sibling_index       = sib_n;
		step_rec.tag_start           = tstart_n;
		step_rec.tag_length          = tlen_ext[4:0];

		verdict_rec              = '0;
		verdict_rec.final_record = 1'b1;
		if (ok) begin
			verdict_rec.accepted            = 1'b1;
			verdict_rec.doc_fragment        = frag_n;
			verdict_rec.has_char_offset     = (phase_n == PH_FRAG_OFF) ||
			                                  (phase_n == PH_OFF_NUM);
			verdict_rec.char_offset         = verdict_rec.has_char_offset ? acc_n : '0;
			verdict_rec.has_text_terminal   = text_seen_n;
			verdict_rec.explicit_text_index = expl_n;
			verdict_rec.text_node_index     = tidx_n;
			verdict_rec.step_count          = steps_n;
		end

		first_rec  = step_emit ? step_rec : verdict_rec;
		second_rec = verdict_rec;
		need       = valid_s1 ? (2'(step_emit) + 2'(last)) : 2'd0;
	end

	// result queue: head at slot 0, shift down on pop
	assign pop  = (cnt_q != 2'd0) && records.ready;
	assign free = 3'(QDEPTH) - {1'b0, cnt_q} + {2'b00, pop};
	assign fire = valid_s1 && ({1'b0, need} <= free);
	assign base = cnt_q - 2'(pop);

	always_comb begin
		for (int i = 0; i < QDEPTH; i++) begin
			slot_n[i] = slot_q[i];
		end
		if (pop) begin
			for (int i = 0; i < QDEPTH - 1; i++) begin
				slot_n[i] = slot_q[i + 1];
			end
		end
		for (int i = 0; i < QDEPTH; i++) begin
			if (fire && (need != 2'd0) && ({1'b0, base} == 3'(i))) begin
				slot_n[i] = first_rec;
			end
			if (fire && (need == 2'd2) && (({1'b0, base} + 3'd1) == 3'(i))) begin
				slot_n[i] = second_rec;
			end
		end
		cnt_n = base + (fire ? need : 2'd0);
	end

	assign bytes.ready     = !valid_s1 || fire;
	assign records.valid   = cnt_q != 2'd0;
	assign records.payload = slot_q[0];

	// input register: hold until parsed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			item_s1 <= bytes.payload;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++) begin
			slot_q[i] <= slot_n[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	// parser state: advance on each parsed beat, drop back to reset after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PREFIX;
			pos_q       <= '0;
			pmi_q       <= '0;
			acc_q       <= '0;
			saw_q       <= 1'b0;
			frag_q      <= '0;
			text_seen_q <= 1'b0;
			expl_q      <= 1'b0;
			tidx_q      <= 16'd1;
			steps_q     <= '0;
			tstart_q    <= '0;
			tlen_q      <= '0;
			word_q      <= '0;
			sib_q       <= 16'd1;
			rej_q       <= 1'b0;
		end else if (fire && last) begin
			phase_q     <= PH_PREFIX;
			pos_q       <= '0;
			pmi_q       <= '0;
			acc_q       <= '0;
			saw_q       <= 1'b0;
			frag_q      <= '0;
			text_seen_q <= 1'b0;
			expl_q      <= 1'b0;
			tidx_q      <= 16'd1;
			steps_q     <= '0;
			tstart_q    <= '0;
			tlen_q      <= '0;
			word_q      <= '0;
			sib_q       <= 16'd1;
			rej_q       <= 1'b0;
		end else if (fire) begin
			phase_q     <= phase_n;
			pos_q       <= pos_n;
			pmi_q       <= pmi_n;
			acc_q       <= acc_n;
			saw_q       <= saw_n;
			frag_q      <= frag_n;
			text_seen_q <= text_seen_n;
			expl_q      <= expl_n;
			tidx_q      <= tidx_n;
			steps_q     <= steps_n;
			tstart_q    <= tstart_n;
			tlen_q      <= tlen_n;
			word_q      <= word_n;
			sib_q       <= sib_n;
			rej_q       <= rej_n;
		end
	end

endmodule

@@ sim/locator_scoreboard.sv @@
`timescale 1ns / 1ps

// Watches both channels, predicts the records of every accepted path byte and
// compares each record beat against the oldest prediction.
module locator_scoreboard #(
	parameter int MAX_PATH_BYTES = 512,
	parameter int MAX_STEPS      = 32,
	parameter int MAX_NAME_BYTES = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	xpl_stream_if byte_ch,
	xpl_stream_if rec_ch,
	output int    fail_count,
	output int    pending_records
);
	import xpl_pkg::*;

	localparam longint unsigned SHORT_LIMIT  = 65535;
	localparam longint unsigned OFFSET_LIMIT = 64'h7FFF_FFFF;
	localparam int unsigned     NOT_TEXT     = 7;
	localparam int              PRINT_CAP    = 50;

	string lead_txt = "/body/DocFragment[";
	string body_txt = "/body";
	string word_txt = "text";

	rec_t        due_q[$];
	phase_t      ph;
	int unsigned bpos, midx, acc, frag, offv, txt_idx, depth, tstart, tlen, word, sib;
	bit          got_digit, off_seen, txt_seen, txt_expl, dead;
	int          errs = 0;
	int          rec_no = 0;

	assign fail_count = errs;

	function automatic void wipe();
		ph        = PH_PREFIX;
		bpos      = 0;
		midx      = 0;
		acc       = 0;
		got_digit = 0;
		frag      = 0;
		offv      = 0;
		off_seen  = 0;
		txt_seen  = 0;
		txt_expl  = 0;
		txt_idx   = 1;
		depth     = 0;
		tstart    = 0;
		tlen      = 0;
		word      = 0;
		dead      = 0;
		sib       = 1;
	endfunction

	function automatic bit is_digit(int unsigned c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_name_start(int unsigned c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit is_name_char(int unsigned c);
		return is_name_start(c) || is_digit(c) || c == "-" || c == ":";
	endfunction

	function automatic void fresh_number();
		acc       = 0;
		got_digit = 0;
	endfunction

	// accumulate one decimal digit; refuse it if the field would overflow
	function automatic bit take_digit(int unsigned c, longint unsigned lim);
		longint unsigned v;
		v = longint'(acc) * 10 + (c - "0");
		if (v > lim)
			return 0;
		acc       = v;
		got_digit = 1;
		return 1;
	endfunction

	task automatic report(input string msg);
		errs++;
		// keep the log short on a badly broken block; the count goes on
		if (errs <= PRINT_CAP)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic cmp(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			report($sformatf("record %0d %s: got %0h, expected %0h", rec_no, name, got, want));
	endtask

	// close the current element step; emit its record if the step is legal
	task automatic end_step();
		rec_t r;
		if (tlen == 0 || tlen >= MAX_NAME_BYTES || depth >= MAX_STEPS) begin
			dead = 1;
			return;
		end
		r               = '0;
		r.accepted      = 1'b1;
		r.doc_fragment  = frag[15:0];
		r.step_count    = depth[5:0];
		r.sibling_index = sib[15:0];
		r.tag_start     = tstart[8:0];
		r.tag_length    = tlen[4:0];
		due_q.push_back(r);
		depth++;
	endtask

	task automatic parse_byte(input int unsigned c, input int unsigned pos);
		case (ph)
			PH_PREFIX: begin
				if (midx < lead_txt.len() && c == lead_txt[midx]) begin
					midx++;
					if (midx == lead_txt.len()) begin
						fresh_number();
						ph = PH_FRAG_NUM;
					end
				end else
					dead = 1;
			end
			PH_FRAG_NUM: begin
				if (is_digit(c)) begin
					if (!take_digit(c, SHORT_LIMIT))
						dead = 1;
				end else if (c == "]" && got_digit && acc != 0) begin
					frag = acc;
					ph   = PH_AFTER_FRAG;
				end else
					dead = 1;
			end
			PH_AFTER_FRAG: begin
				if (c == ".") begin
					fresh_number();
					ph = PH_FRAG_OFF;
				end else if (c == "/") begin
					midx = 1;
					ph   = PH_BODY;
				end else
					dead = 1;
			end
			PH_BODY: begin
				if (midx < body_txt.len() && c == body_txt[midx]) begin
					midx++;
					if (midx == body_txt.len())
						ph = PH_BODY_DONE;
				end else
					dead = 1;
			end
			PH_BODY_DONE: begin
				if (c == "/")
					ph = PH_BODY_SLASH;
				else
					dead = 1;
			end
			PH_BODY_SLASH, PH_STEP_SLASH: begin
				if (is_name_start(c)) begin
					tstart = pos;
					tlen   = 1;
					word   = (c == "t") ? 1 : NOT_TEXT;
					sib    = 1;
					ph     = PH_TAG;
				end else
					dead = 1;
			end
			PH_TAG: begin
				if (is_name_char(c)) begin
					if (tlen < 255)
						tlen++;
					if (word < 4 && c == word_txt[word])
						word++;
					else
						word = NOT_TEXT;
				end else if (c == "(") begin
					if (word == 4 && depth > 0)
						ph = PH_TEXT_CLOSE;
					else
						dead = 1;
				end else if (c == "[") begin
					fresh_number();
					ph = PH_SIB_NUM;
				end else if (c == "/") begin
					end_step();
					ph = PH_STEP_SLASH;
				end else if (c == ".") begin
					end_step();
					fresh_number();
					ph = PH_OFF_NUM;
				end else
					dead = 1;
			end
			PH_SIB_NUM: begin
				if (is_digit(c)) begin
					if (!take_digit(c, SHORT_LIMIT))
						dead = 1;
				end else if (c == "]" && got_digit) begin
					sib = (acc != 0) ? acc : 1;
					end_step();
					ph = PH_AFTER_STEP;
				end else
					dead = 1;
			end
			PH_AFTER_STEP: begin
				if (c == "/")
					ph = PH_STEP_SLASH;
				else if (c == ".") begin
					fresh_number();
					ph = PH_OFF_NUM;
				end else
					dead = 1;
			end
			PH_TEXT_CLOSE: begin
				if (c == ")") begin
					txt_seen = 1;
					ph       = PH_TEXT_AFTER;
				end else
					dead = 1;
			end
			PH_TEXT_AFTER: begin
				if (c == "[") begin
					fresh_number();
					ph = PH_TEXT_NUM;
				end else if (c == ".") begin
					fresh_number();
					ph = PH_OFF_NUM;
				end else
					dead = 1;
			end
			PH_TEXT_NUM: begin
				if (is_digit(c)) begin
					if (!take_digit(c, SHORT_LIMIT))
						dead = 1;
				end else if (c == "]" && got_digit && acc != 0) begin
					txt_idx  = acc;
					txt_expl = 1;
					ph       = PH_TEXT_DONE;
				end else
					dead = 1;
			end
			PH_TEXT_DONE: begin
				if (c == ".") begin
					fresh_number();
					ph = PH_OFF_NUM;
				end else
					dead = 1;
			end
			PH_FRAG_OFF, PH_OFF_NUM: begin
				if (!is_digit(c) || !take_digit(c, OFFSET_LIMIT))
					dead = 1;
			end
			default: dead = 1;
		endcase
	endtask

	// decide the verdict on the last byte of a path
	task automatic close_path(output bit ok);
		case (ph)
			PH_AFTER_FRAG, PH_BODY_DONE, PH_BODY_SLASH, PH_AFTER_STEP: ok = 1;
			PH_TAG: begin
				end_step();
				ok = !dead;
			end
			PH_FRAG_OFF, PH_OFF_NUM: begin
				if (!got_digit || (ph == PH_FRAG_OFF && acc != 0))
					ok = 0;
				else begin
					offv     = acc;
					off_seen = 1;
					ok       = 1;
				end
			end
			default: ok = 0;
		endcase
	endtask

	task automatic absorb(input int unsigned c, input bit last);
		int unsigned pos;
		bit          ok;
		rec_t        r;
		pos = bpos;
		if (bpos <= MAX_PATH_BYTES)
			bpos++;
		if (bpos > MAX_PATH_BYTES)
			dead = 1;
		if (!dead)
			parse_byte(c, pos);
		if (last) begin
			ok = 0;
			if (!dead)
				close_path(ok);
			r              = '0;
			r.final_record = 1'b1;
			if (ok) begin
				r.accepted            = 1'b1;
				r.doc_fragment        = frag[15:0];
				r.char_offset         = off_seen ? offv[30:0] : 31'd0;
				r.has_char_offset     = off_seen;
				r.has_text_terminal   = txt_seen;
				r.explicit_text_index = txt_expl;
				r.text_node_index     = txt_idx[15:0];
				r.step_count          = depth[5:0];
			end
			due_q.push_back(r);
			wipe();
		end
	endtask

	task automatic check_rec(input rec_t got);
		rec_t want;
		if (due_q.size() == 0) begin
			report($sformatf("record %0d arrived with nothing expected: %h", rec_no, got));
			rec_no++;
			return;
		end
		want = due_q.pop_front();
		cmp("final_record", got.final_record, want.final_record);
		cmp("accepted", got.accepted, want.accepted);
		cmp("doc_fragment", got.doc_fragment, want.doc_fragment);
		cmp("char_offset", got.char_offset, want.char_offset);
		cmp("has_char_offset", got.has_char_offset, want.has_char_offset);
		cmp("has_text_terminal", got.has_text_terminal, want.has_text_terminal);
		cmp("explicit_text_index", got.explicit_text_index, want.explicit_text_index);
		cmp("text_node_index", got.text_node_index, want.text_node_index);
		cmp("step_count", got.step_count, want.step_count);
		cmp("sibling_index", got.sibling_index, want.sibling_index);
		cmp("tag_start", got.tag_start, want.tag_start);
		cmp("tag_length", got.tag_length, want.tag_length);
		rec_no++;
	endtask

	// compare before predicting: a byte never yields a record in its own cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe();
			due_q.delete();
			pending_records <= 0;
		end else begin
			if (rec_ch.valid && rec_ch.ready)
				check_rec(rec_ch.payload);
			if (byte_ch.valid && byte_ch.ready)
				absorb(byte_ch.payload.char_byte, byte_ch.payload.end_of_string);
			pending_records <= due_q.size();
		end
	end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

// Path byte stimulus for the locator parser. A directed set of paths walks the
// grammar's corners and limits, then random paths (mostly well formed, some
// damaged) run with random gaps on both sides. The scoreboard beside the block
// does all prediction and comparison; this module only drives and judges.
module testbench;
	import xpl_pkg::*;

	localparam int MAX_PATH_BYTES = 512;
	localparam int MAX_STEPS      = 32;
	localparam int MAX_NAME_BYTES = 32;
	localparam int RANDOM_BYTES   = 1850;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 32;
	localparam int CYCLE_LIMIT    = 1_000_000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	xpl_stream_if #(.payload_t(in_item_t)) byte_ch ();
	xpl_stream_if #(.payload_t(rec_t))     rec_ch ();

	int         fail_count;
	int         pending_records;
	int         sent_bytes  = 0;
	int         cycle_count = 0;
	bit         tx_burst    = 0;
	bit         rx_burst    = 0;
	bit         hold_req    = 0;
	logic [7:0] path_buf[$];

	// names that walk partway into, exactly onto, and past the text() keyword
	string odd_names[6] = '{"t", "te", "tex", "text", "texts", "textual"};
	// bytes that the grammar cares about, for insertion damage
	string junk = "/[]().0a9tx_";

	always #2 clk = ~clk;

	xpath_locator_parser #(
		.MAX_PATH_BYTES(MAX_PATH_BYTES),
		.MAX_STEPS     (MAX_STEPS),
		.MAX_NAME_BYTES(MAX_NAME_BYTES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.records(rec_ch)
	);

	locator_scoreboard #(
		.MAX_PATH_BYTES(MAX_PATH_BYTES),
		.MAX_STEPS     (MAX_STEPS),
		.MAX_NAME_BYTES(MAX_NAME_BYTES)
	) board (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_ch        (byte_ch),
		.rec_ch         (rec_ch),
		.fail_count     (fail_count),
		.pending_records(pending_records)
	);

	// ---------------------------------------------------------------- path building

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			path_buf.push_back(s[i]);
	endtask

	task automatic add_num(input longint unsigned v);
		add_str($sformatf("%0d", v));
	endtask

	// decimal field; now and then drop it entirely or pad it with a leading zero
	task automatic add_field(input longint unsigned v);
		if ($urandom_range(0, 15) == 0)
			return;
		if ($urandom_range(0, 9) == 0)
			add_str("0");
		add_num(v);
	endtask

	function automatic logic [7:0] pick_name_char(input bit lead);
		string starts;
		string others;
		starts = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
		others = "0123456789-:";
		if (lead || $urandom_range(0, 3) != 0)
			return starts[$urandom_range(0, starts.len() - 1)];
		return others[$urandom_range(0, others.len() - 1)];
	endfunction

	// one element step: slash plus a random name of the given length
	task automatic add_step(input int len);
		path_buf.push_back("/");
		for (int i = 0; i < len; i++)
			path_buf.push_back(pick_name_char(i == 0));
	endtask

	// fragment, sibling and text indexes: zero, the top, just past the top, typical
	function automatic longint unsigned pick_index();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return 65535;
			2:       return 65536 + $urandom_range(0, 500000);
			3:       return $urandom_range(1, 9);
			default: return $urandom_range(1, 65535);
		endcase
	endfunction

	function automatic longint unsigned pick_offset();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return 64'd2147483647;
			2:       return 64'd2147483648 + $urandom_range(0, 1000);
			3:       return $urandom_range(0, 99);
			default: return $urandom & 32'h7FFF_FFFF;
		endcase
	endfunction

	// Build a random path: mostly legal shapes with random content, then damage
	// a few of them by overwriting, cutting short or inserting a byte.
	task automatic make_random_path();
		int n;
		int keep;
		path_buf.delete();
		add_str("/body/DocFragment[");
		add_field(pick_index());
		add_str("]");
		case ($urandom_range(0, 11))
			0: ;
			1: begin
				add_str(".");
				if ($urandom_range(0, 2) == 0)
					add_field(pick_offset());
				else
					add_str("0");
			end
			2: add_str("/body");
			3: add_str("/body/");
			default: begin
				add_str("/body");
				n = ($urandom_range(0, 29) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 5);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 7) == 0) begin
						path_buf.push_back("/");
						add_str(odd_names[$urandom_range(0, 5)]);
					end else if ($urandom_range(0, 39) == 0)
						add_step($urandom_range(29, 34));
					else
						add_step($urandom_range(1, 8));
					if ($urandom_range(0, 2) == 0) begin
						add_str("[");
						add_field(pick_index());
						add_str("]");
					end
				end
				case ($urandom_range(0, 5))
					0, 1: begin
						add_str("/text()");
						if ($urandom_range(0, 1) == 0) begin
							add_str("[");
							add_field(pick_index());
							add_str("]");
						end
						// the offset is required here; leave it off once in a while
						if ($urandom_range(0, 7) != 0) begin
							add_str(".");
							add_field(pick_offset());
						end
					end
					2: begin
						add_str(".");
						add_field(pick_offset());
					end
					3: if ($urandom_range(0, 3) == 0) add_str("/");
					default: ;
				endcase
			end
		endcase
		case ($urandom_range(0, 9))
			0: path_buf[$urandom_range(0, path_buf.size() - 1)] = 8'($urandom_range(0, 255));
			1: begin
				keep = $urandom_range(1, path_buf.size());
				while (path_buf.size() > keep)
					void'(path_buf.pop_back());
			end
			2: path_buf.insert($urandom_range(0, path_buf.size() - 1),
				junk[$urandom_range(0, junk.len() - 1)]);
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------- driving

	// Offer one beat after a random gap; hold valid high across back-to-back
	// beats so it is never dropped and raised in the same step.
	task automatic push_byte(input logic [7:0] b, input bit last);
		int       gap;
		in_item_t beat;
		gap = tx_burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		beat.char_byte     = b;
		beat.end_of_string = last;
		byte_ch.valid   <= 1'b1;
		byte_ch.payload <= beat;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		sent_bytes++;
	endtask

	// send the buffered path; pick per path whether the sender runs gap-free
	task automatic send_path();
		tx_burst = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < path_buf.size(); i++)
			push_byte(path_buf[i], i == path_buf.size() - 1);
	endtask

	task automatic send_text(input string s);
		path_buf.delete();
		add_str(s);
		send_path();
	endtask

	task automatic send_single(input logic [7:0] b);
		path_buf.delete();
		path_buf.push_back(b);
		send_path();
	endtask

	// Drop valid, let the scoreboard count take in the last beat, then hold
	// until every predicted record has come back.
	task automatic drain();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_records != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------- stimulus

	initial begin
		int base;
		int paths;
		byte_ch.valid   = 1'b0;
		byte_ch.payload = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// prefix and fragment number: bounds, zero, overflow, empty, offset rules
		send_text("/body/DocFragment[1]");
		send_text("/body/DocFragment[65535].0");
		send_text("/body/DocFragment[65536]");
		send_text("/body/DocFragment[0]");
		send_text("/body/DocFragment[]");
		send_text("/body/DocFragment[3].5");
		send_text("/body/DocFragment[3].00");
		send_text("/body/DocFragment[3].");
		send_text("/body/Docfragment[3]");
		send_text("/body/DocFragment[3]x");
		// body endings
		send_text("/body/DocFragment[12]/body");
		send_text("/body/DocFragment[12]/body/");
		send_text("/body/DocFragment[12]/bodx");
		// steps, sibling indexes (zero maps to one), offset bounds
		send_text("/body/DocFragment[7]/body/p[0]/span[65535]/a.2147483647");
		send_text("/body/DocFragment[7]/body/p[65536]");
		send_text("/body/DocFragment[7]/body/p.2147483648");
		send_text("/body/DocFragment[7]/body/p[]");
		send_text("/body/DocFragment[7]/body/x/");
		send_text("/body/DocFragment[7]/body/9a");
		send_text("/body/DocFragment[7]/body/text/texts/Tex:t-_9/Z");
		// text() terminal: plain, indexed, zero index, missing offset, no step before
		send_text("/body/DocFragment[7]/body/div/text().0");
		send_text("/body/DocFragment[7]/body/div/text()[65535].12");
		send_text("/body/DocFragment[7]/body/div/text()[0].1");
		send_text("/body/DocFragment[7]/body/div/text()");
		send_text("/body/DocFragment[7]/body/text().3");
		// one-byte strings, including the byte extremes
		send_single(8'hFF);
		send_single(8'h00);
		send_single("/");

		// name length just under and at the limit
		path_buf.delete();
		add_str("/body/DocFragment[2]/body");
		add_step(MAX_NAME_BYTES - 1);
		add_str("[1]");
		send_path();
		path_buf.delete();
		add_str("/body/DocFragment[2]/body");
		add_step(MAX_NAME_BYTES);
		send_path();

		// depth: text() is still fine after the last allowed step, one more step is not
		path_buf.delete();
		add_str("/body/DocFragment[3]/body");
		repeat (MAX_STEPS) add_step(1);
		add_str("/text().4");
		send_path();
		path_buf.delete();
		add_str("/body/DocFragment[3]/body");
		repeat (MAX_STEPS + 1) add_step(1);
		send_path();

		// Length: exactly the maximum with the last name at the top byte position,
		// then one byte more. 25 + 15*32 + 5 bytes put the final slash at 510.
		for (int extra = 0; extra < 2; extra++) begin
			path_buf.delete();
			add_str("/body/DocFragment[4]/body");
			repeat (15) add_step(31);
			add_step(4);
			add_step(1 + extra);
			send_path();
		end

		// random paths; stall the receiver early on and let the sender run dry once
		base  = sent_bytes;
		paths = 0;
		while (sent_bytes - base < RANDOM_BYTES) begin
			make_random_path();
			send_path();
			paths++;
			if (paths == 4)
				hold_req = 1;
			if (paths == 12)
				drain();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("xpath_locator_parser regression: pass");
		else
			$display("xpath_locator_parser regression: fail");
		$finish;
	end

	// ---------------------------------------------------------------- record sink

	// Take records with a random wait before each beat, switching now and then
	// into gap-free stretches; on request hold ready low for a long stretch so
	// the result queue fills and the block pushes back on the byte channel.
	initial begin
		int gap;
		rec_ch.ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				rec_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end
			gap = rx_burst ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				rec_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rec_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rec_ch.valid)
				@(posedge clk);
			if ($urandom_range(0, 24) == 0)
				rx_burst = !rx_burst;
		end
	end

	// ---------------------------------------------------------------- watchdog

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("xpath_locator_parser regression: fail");
		$finish;
	end

endmodule
